FILE: rtl/core/bco_pkg.sv
// Shared types for the box and circle overlap test.
`timescale 1ns / 1ps

package bco_pkg;

  typedef enum logic [1:0] {
    PAIR_BOX_BOX       = 2'd0,
    PAIR_BOX_CIRCLE    = 2'd1,
    PAIR_CIRCLE_CIRCLE = 2'd2
  } pair_e;

endpackage

FILE: rtl/core/bco_req_if.sv
// Request channel carrying one shape pair per word.
`timescale 1ns / 1ps

interface bco_req_if #(
  parameter int unsigned COORD_BITS = 16
);

  logic                          valid;
  logic                          ready;
  logic [1:0]                    req_type;
  logic signed [COORD_BITS-1:0]  first_x;
  logic signed [COORD_BITS-1:0]  first_y;
  logic [COORD_BITS-3:0]         first_size_x;
  logic [COORD_BITS-3:0]         first_size_y;
  logic signed [COORD_BITS-1:0]  second_x;
  logic signed [COORD_BITS-1:0]  second_y;
  logic [COORD_BITS-3:0]         second_size_x;
  logic [COORD_BITS-3:0]         second_size_y;

  modport source (
    output valid, req_type, first_x, first_y, first_size_x, first_size_y,
           second_x, second_y, second_size_x, second_size_y,
    input  ready
  );

  modport sink (
    input  valid, req_type, first_x, first_y, first_size_x, first_size_y,
           second_x, second_y, second_size_x, second_size_y,
    output ready
  );

endinterface

FILE: rtl/core/bco_rsp_if.sv
// Response channel carrying one overlap flag per word.
`timescale 1ns / 1ps

interface bco_rsp_if;

  logic valid;
  logic ready;
  logic colliding;

  modport source (
    output valid, colliding,
    input  ready
  );

  modport sink (
    input  valid, colliding,
    output ready
  );

endinterface

FILE: rtl/core/bco_delta.sv
// Centre differences, limit selection and difference magnitudes (two stages).
`timescale 1ns / 1ps

module bco_delta #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  logic [1:0]                   req_type_i,
  input  logic signed [COORD_BITS-1:0] first_x_i,
  input  logic signed [COORD_BITS-1:0] first_y_i,
  input  logic [COORD_BITS-3:0]        first_size_x_i,
  input  logic [COORD_BITS-3:0]        first_size_y_i,
  input  logic signed [COORD_BITS-1:0] second_x_i,
  input  logic signed [COORD_BITS-1:0] second_y_i,
  input  logic [COORD_BITS-3:0]        second_size_x_i,
  input  logic [COORD_BITS-3:0]        second_size_y_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output bco_pkg::pair_e               mode_o,
  output logic [COORD_BITS-1:0]        adx_o,
  output logic [COORD_BITS-1:0]        ady_o,
  output logic [COORD_BITS-2:0]        lim_x_o,
  output logic [COORD_BITS-2:0]        lim_y_o,
  output logic [COORD_BITS-2:0]        rad_o
);
  import bco_pkg::*;

  logic                        en1, en2;
  logic                        v1_q, v2_q;
  logic signed [COORD_BITS:0]  dx_d, dy_d, dx_q, dy_q;
  logic [COORD_BITS-2:0]       sum_x, sum_y;
  logic [COORD_BITS-2:0]       lim_x_d, lim_y_d, rad_d;
  logic [COORD_BITS-2:0]       lim_x1_q, lim_y1_q, rad1_q;
  logic [COORD_BITS-2:0]       lim_x2_q, lim_y2_q, rad2_q;
  pair_e                       mode_d, mode1_q, mode2_q;
  logic [COORD_BITS:0]         neg_x, neg_y;
  logic [COORD_BITS-1:0]       adx_d, ady_d, adx_q, ady_q;

  assign en2     = !v2_q || ready_i;
  assign en1     = !v1_q || en2;
  assign ready_o = en1;

  assign mode_d = pair_e'(req_type_i);
  assign dx_d   = $signed({second_x_i[COORD_BITS-1], second_x_i})
                - $signed({first_x_i[COORD_BITS-1], first_x_i});
  assign dy_d   = $signed({second_y_i[COORD_BITS-1], second_y_i})
                - $signed({first_y_i[COORD_BITS-1], first_y_i});
  assign sum_x  = {1'b0, first_size_x_i} + {1'b0, second_size_x_i};
  assign sum_y  = {1'b0, first_size_y_i} + {1'b0, second_size_y_i};

  always_comb begin
    unique case (mode_d)
      PAIR_BOX_BOX: begin
        lim_x_d = sum_x;
        lim_y_d = sum_y;
        rad_d   = '0;
      end
      PAIR_BOX_CIRCLE: begin
        lim_x_d = {1'b0, first_size_x_i};
        lim_y_d = {1'b0, first_size_y_i};
        rad_d   = {1'b0, second_size_x_i};
      end
      PAIR_CIRCLE_CIRCLE: begin
        lim_x_d = '0;
        lim_y_d = '0;
        rad_d   = sum_x;
      end
      default: begin
        lim_x_d = '0;
        lim_y_d = '0;
        rad_d   = '0;
      end
    endcase
  end

  assign neg_x = -dx_q;
  assign neg_y = -dy_q;
  assign adx_d = dx_q[COORD_BITS] ? neg_x[COORD_BITS-1:0] : dx_q[COORD_BITS-1:0];
  assign ady_d = dy_q[COORD_BITS] ? neg_y[COORD_BITS-1:0] : dy_q[COORD_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && valid_i) begin
      mode1_q  <= mode_d;
      dx_q     <= dx_d;
      dy_q     <= dy_d;
      lim_x1_q <= lim_x_d;
      lim_y1_q <= lim_y_d;
      rad1_q   <= rad_d;
    end
    if (en2 && v1_q) begin
      mode2_q  <= mode1_q;
      adx_q    <= adx_d;
      ady_q    <= ady_d;
      lim_x2_q <= lim_x1_q;
      lim_y2_q <= lim_y1_q;
      rad2_q   <= rad1_q;
    end
  end

  assign valid_o = v2_q;
  assign mode_o  = mode2_q;
  assign adx_o   = adx_q;
  assign ady_o   = ady_q;
  assign lim_x_o = lim_x2_q;
  assign lim_y_o = lim_y2_q;
  assign rad_o   = rad2_q;

endmodule

FILE: rtl/core/bco_excess.sv
// Distance left over after the box extents and per-axis box overlap (one stage).
`timescale 1ns / 1ps

module bco_excess #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  bco_pkg::pair_e        mode_i,
  input  logic [COORD_BITS-1:0] adx_i,
  input  logic [COORD_BITS-1:0] ady_i,
  input  logic [COORD_BITS-2:0] lim_x_i,
  input  logic [COORD_BITS-2:0] lim_y_i,
  input  logic [COORD_BITS-2:0] rad_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output bco_pkg::pair_e        mode_o,
  output logic [COORD_BITS-1:0] ex_o,
  output logic [COORD_BITS-1:0] ey_o,
  output logic                  box_hit_o,
  output logic [COORD_BITS-2:0] rad_o
);
  import bco_pkg::*;

  logic                  en, v_q;
  logic [COORD_BITS-1:0] lim_x_ext, lim_y_ext;
  logic                  over_x, over_y;
  logic [COORD_BITS-1:0] ex_d, ey_d, ex_q, ey_q;
  logic                  box_hit_q;
  logic [COORD_BITS-2:0] rad_q;
  pair_e                 mode_q;

  assign en      = !v_q || ready_i;
  assign ready_o = en;

  assign lim_x_ext = {1'b0, lim_x_i};
  assign lim_y_ext = {1'b0, lim_y_i};
  assign over_x    = adx_i > lim_x_ext;
  assign over_y    = ady_i > lim_y_ext;
  assign ex_d      = over_x ? adx_i - lim_x_ext : '0;
  assign ey_d      = over_y ? ady_i - lim_y_ext : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && valid_i) begin
      mode_q    <= mode_i;
      ex_q      <= ex_d;
      ey_q      <= ey_d;
      box_hit_q <= !over_x && !over_y;
      rad_q     <= rad_i;
    end
  end

  assign valid_o   = v_q;
  assign mode_o    = mode_q;
  assign ex_o      = ex_q;
  assign ey_o      = ey_q;
  assign box_hit_o = box_hit_q;
  assign rad_o     = rad_q;

endmodule

FILE: rtl/core/bco_dist.sv
// Squared distance against squared radius and the output register (two stages).
`timescale 1ns / 1ps

module bco_dist #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  bco_pkg::pair_e        mode_i,
  input  logic [COORD_BITS-1:0] ex_i,
  input  logic [COORD_BITS-1:0] ey_i,
  input  logic                  box_hit_i,
  input  logic [COORD_BITS-2:0] rad_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output logic                  colliding_o
);
  import bco_pkg::*;

  logic                      en4, en5;
  logic                      v4_q, v5_q;
  logic [2*COORD_BITS-1:0]   sq_x_d, sq_y_d, sq_x_q, sq_y_q;
  logic [2*COORD_BITS-3:0]   r2_d, r2_q;
  logic                      box_hit_q;
  pair_e                     mode_q;
  logic [2*COORD_BITS:0]     dist2;
  logic                      inside_r;
  logic                      hit_d, hit_q;

  assign en5     = !v5_q || ready_i;
  assign en4     = !v4_q || en5;
  assign ready_o = en4;

  assign sq_x_d = (2*COORD_BITS)'(ex_i) * (2*COORD_BITS)'(ex_i);
  assign sq_y_d = (2*COORD_BITS)'(ey_i) * (2*COORD_BITS)'(ey_i);
  assign r2_d   = (2*COORD_BITS-2)'(rad_i) * (2*COORD_BITS-2)'(rad_i);

  assign dist2    = {1'b0, sq_x_q} + {1'b0, sq_y_q};
  assign inside_r = dist2 < {3'b000, r2_q};

  always_comb begin
    unique case (mode_q)
      PAIR_BOX_BOX:       hit_d = box_hit_q;
      PAIR_BOX_CIRCLE:    hit_d = inside_r;
      PAIR_CIRCLE_CIRCLE: hit_d = inside_r;
      default:            hit_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en4) v4_q <= valid_i;
      if (en5) v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4 && valid_i) begin
      mode_q    <= mode_i;
      sq_x_q    <= sq_x_d;
      sq_y_q    <= sq_y_d;
      r2_q      <= r2_d;
      box_hit_q <= box_hit_i;
    end
    if (en5 && v4_q) begin
      hit_q <= hit_d;
    end
  end

  assign valid_o     = v5_q;
  assign colliding_o = hit_q;

endmodule

FILE: rtl/core/box_circle_overlap_test.sv
// Top level of the pipelined 2D box and circle overlap test.
// Each request word holds two shapes and a pair type (box-box, box-circle with the
// box first, or circle-circle) and yields one response word whose colliding flag
// tells whether the shapes overlap; touching boxes collide, while circle tests are
// strict, and the unused pair type answers 0. A new word is taken every cycle while the
// response side does not stall, and its response word passes through the five
// register stages (centre difference, magnitude, excess over the box extents,
// squaring, and the final compare that feeds the output register). Request ready
// drops only when the output register holds an untaken word and every stage behind
// it is occupied.
`timescale 1ns / 1ps

module box_circle_overlap_test #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bco_req_if.sink   req_i,
  bco_rsp_if.source rsp_o
);
  import bco_pkg::*;

  logic                  d_valid, d_ready;
  pair_e                 d_mode;
  logic [COORD_BITS-1:0] d_adx, d_ady;
  logic [COORD_BITS-2:0] d_lim_x, d_lim_y, d_rad;

  logic                  e_valid, e_ready;
  pair_e                 e_mode;
  logic [COORD_BITS-1:0] e_ex, e_ey;
  logic                  e_box_hit;
  logic [COORD_BITS-2:0] e_rad;

  bco_delta #(.COORD_BITS(COORD_BITS)) u_delta (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (req_i.valid),
    .ready_o        (req_i.ready),
    .req_type_i     (req_i.req_type),
    .first_x_i      (req_i.first_x),
    .first_y_i      (req_i.first_y),
    .first_size_x_i (req_i.first_size_x),
    .first_size_y_i (req_i.first_size_y),
    .second_x_i     (req_i.second_x),
    .second_y_i     (req_i.second_y),
    .second_size_x_i(req_i.second_size_x),
    .second_size_y_i(req_i.second_size_y),
    .valid_o        (d_valid),
    .ready_i        (d_ready),
    .mode_o         (d_mode),
    .adx_o          (d_adx),
    .ady_o          (d_ady),
    .lim_x_o        (d_lim_x),
    .lim_y_o        (d_lim_y),
    .rad_o          (d_rad)
  );

  bco_excess #(.COORD_BITS(COORD_BITS)) u_excess (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (d_valid),
    .ready_o  (d_ready),
    .mode_i   (d_mode),
    .adx_i    (d_adx),
    .ady_i    (d_ady),
    .lim_x_i  (d_lim_x),
    .lim_y_i  (d_lim_y),
    .rad_i    (d_rad),
    .valid_o  (e_valid),
    .ready_i  (e_ready),
    .mode_o   (e_mode),
    .ex_o     (e_ex),
    .ey_o     (e_ey),
    .box_hit_o(e_box_hit),
    .rad_o    (e_rad)
  );

  bco_dist #(.COORD_BITS(COORD_BITS)) u_dist (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (e_valid),
    .ready_o    (e_ready),
    .mode_i     (e_mode),
    .ex_i       (e_ex),
    .ey_i       (e_ey),
    .box_hit_i  (e_box_hit),
    .rad_i      (e_rad),
    .valid_o    (rsp_o.valid),
    .ready_i    (rsp_o.ready),
    .colliding_o(rsp_o.colliding)
  );

endmodule

FILE: rtl/core/bco_checker.sv
// Port-level assertions for the overlap test and their binding to the top level.
`timescale 1ns / 1ps

module bco_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic req_valid_i,
  input logic req_ready_i,
  input logic rsp_valid_i,
  input logic rsp_ready_i,
  input logic colliding_i
);

  logic req_acc;

  assign req_acc = req_valid_i && req_ready_i;

  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !rsp_valid_i)
    else $error("Response word shown right after reset.");

  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_ready_i |-> req_ready_i)
    else $error("Request stalled although the response side takes words.");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc ##1 rsp_ready_i ##1 rsp_ready_i ##1 rsp_ready_i ##1 rsp_ready_i
    |=> rsp_valid_i)
    else $error("Response word missing five cycles after an unstalled request.");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(colliding_i))
    else $error("Stalled response word changed or vanished.");

endmodule

bind box_circle_overlap_test bco_checker u_bco_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .req_valid_i(req_i.valid),
  .req_ready_i(req_i.ready),
  .rsp_valid_i(rsp_o.valid),
  .rsp_ready_i(rsp_o.ready),
  .colliding_i(rsp_o.colliding)
);
